[design/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define MSLP_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("mslp check failed");

// ante at one edge implies cons at the next edge, outside reset
`define MSLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mslp check failed");

// ante at one edge implies cons at the next edge, reset included
`define MSLP_ASSERT_NEXT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("mslp check failed");

`endif

[design/mslp_pkg.sv]
// Shared constants and types of the mid-square linear probe hash table
package mslp_pkg;

   localparam int TABLE_SIZE_DEFAULT = 16;
   localparam int KEY_W              = 32;
   localparam int SLOT_W             = 4;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic                    ok;
      logic signed [KEY_W-1:0] found_key;
      logic [SLOT_W-1:0]       slot;
   } rsp_type;

endpackage

[design/mslp_ram.sv]
// Generic single write port RAM with registered read
module mslp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mslp_front.sv]
// Front end: accepts requests, squares the key and derives the home bucket
module mslp_front #(
   parameter int TABLE_SIZE = mslp_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic signed [mslp_pkg::KEY_W-1:0]      req_key,
   input  logic                                   clearing,
   input  logic                                   q_full,
   output logic                                   push,
   output logic [1+mslp_pkg::KEY_W+$clog2(TABLE_SIZE)-1:0] push_data
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int SHIFT = (mslp_pkg::KEY_W - IDX_W) / 2;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_op_ff;
   logic [mslp_pkg::KEY_W-1:0]  s1_key_ff;
   logic [mslp_pkg::KEY_W-1:0]  s1_sq_ff;
   logic [mslp_pkg::KEY_W-1:0]  key_u;
   logic                        accept;
   logic [IDX_W-1:0]            field;
   logic [IDX_W-1:0]            home;

   assign key_u     = $unsigned(req_key);
   assign req_stall = clearing | (s1_valid_ff & q_full);
   assign accept    = req_valid & ~req_stall;
   assign push      = s1_valid_ff & ~q_full;

   assign field = s1_sq_ff[SHIFT +: IDX_W];
   assign home  = ({1'b0, field} >= (IDX_W+1)'(TABLE_SIZE))
                ? IDX_W'({1'b0, field} - (IDX_W+1)'(TABLE_SIZE)) : field;

   assign push_data = {s1_op_ff, s1_key_ff, home};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_op_ff  <= req_operation;
         s1_key_ff <= key_u;
         s1_sq_ff  <= mslp_pkg::KEY_W'(key_u * key_u);
      end
   end

endmodule

[design/mslp_queue.sv]
// Short FIFO between the front end and the probe engine
module mslp_queue #(
   parameter int WIDTH = 37,
   parameter int DEPTH = mslp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/mslp_back.sv]
// Probe engine: clears the store, walks buckets and registers the response
module mslp_back #(
   parameter int TABLE_SIZE = mslp_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  logic [1+mslp_pkg::KEY_W+$clog2(TABLE_SIZE)-1:0] q_data,
   output logic                                   q_pop,
   output logic                                   clearing,
   output logic                                   wr_en,
   output logic [$clog2(TABLE_SIZE)-1:0]          wr_addr,
   output logic [mslp_pkg::KEY_W-1:0]             wr_data,
   output logic [$clog2(TABLE_SIZE)-1:0]          rd_addr,
   input  logic [mslp_pkg::KEY_W-1:0]             rd_data,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output mslp_pkg::rsp_type                      rsp
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int KW    = mslp_pkg::KEY_W;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_PROBE
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mslp_pkg::rsp_type rsp_ff, rsp_in;
   logic              op_ff, op_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  n_ff, n_in;

   logic              q_op;
   logic [KW-1:0]     q_key;
   logic [IDX_W-1:0]  q_home;
   logic [IDX_W-1:0]  next_idx;
   logic              last;
   logic              slot_empty;
   logic              hit;

   assign {q_op, q_key, q_home} = q_data;
   assign next_idx   = (cur_ff == IDX_W'(TABLE_SIZE-1)) ? '0 : cur_ff + 1'b1;
   assign last       = n_ff == IDX_W'(TABLE_SIZE-1);
   assign slot_empty = rd_data == '0;
   assign hit        = rd_data == key_ff;

   assign clearing  = state_ff == B_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      logic done;
      logic ok;
      done         = 1'b0;
      ok           = 1'b0;
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      q_pop        = 1'b0;
      rd_addr      = next_idx;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = key_ff;
      unique case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_SIZE-1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            rd_addr = q_home;
            if (q_valid && (!rsp_valid_ff || !rsp_stall)) begin
               q_pop    = 1'b1;
               op_in    = q_op;
               key_in   = q_key;
               cur_in   = q_home;
               n_in     = '0;
               state_in = B_PROBE;
            end
         end
         B_PROBE: begin
            if (op_ff == mslp_pkg::OP_INSERT) begin
               if (slot_empty) begin
                  done  = 1'b1;
                  ok    = 1'b1;
                  wr_en = 1'b1;
               end else if (last) begin
                  done = 1'b1;
               end
            end else begin
               if (slot_empty) begin
                  done = 1'b1;
               end else if (hit) begin
                  done = 1'b1;
                  ok   = 1'b1;
               end else if (last) begin
                  done = 1'b1;
               end
            end
            if (done) begin
               rsp_valid_in     = 1'b1;
               rsp_in.ok        = ok;
               rsp_in.found_key = (ok && op_ff == mslp_pkg::OP_SEARCH)
                                ? $signed(key_ff) : '0;
               rsp_in.slot      = ok ? mslp_pkg::SLOT_W'(cur_ff) : '0;
               state_in         = B_IDLE;
            end else begin
               cur_in = next_idx;
               n_in   = n_ff + 1'b1;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      op_ff  <= op_in;
      key_ff <= key_in;
      cur_ff <= cur_in;
      n_ff   <= n_in;
   end

endmodule

[design/mid_square_linear_probe_hash_table_unit.sv]
// Top level of the mid-square linear probe hash table
//
// Requests (req_*) carry an operation (insert or search) and a 32-bit key;
// each request yields exactly one response beat on rsp_*, in order.
// Both channels move a beat when valid is high and stall is low.
// The front end registers the key square, then pushes the key and its home
// bucket into a two-entry queue, so requests keep flowing while the probe
// engine is busy or the response side stalls.
// The probe engine reads one bucket of the slot RAM per cycle while probing;
// a beat is started from the idle state and then probes p buckets, p between
// 1 and TABLE_SIZE; the engine takes no new beat until the last one is done.
// After reset the RAM is cleared one slot per cycle, slot by slot in order;
// req_stall stays high during that sweep.
// A stalled response holds in its output register; the engine waits to
// start the next beat, and the queue then fills and raises req_stall.
module mid_square_linear_probe_hash_table_unit #(
   parameter int TABLE_SIZE = mslp_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_operation,
   input  logic signed [mslp_pkg::KEY_W-1:0]      req_key,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_ok,
   output logic signed [mslp_pkg::KEY_W-1:0]      rsp_found_key,
   output logic [mslp_pkg::SLOT_W-1:0]            rsp_slot
);

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int ITEM_W = 1 + mslp_pkg::KEY_W + IDX_W;

   logic                       clearing;
   logic                       q_full;
   logic                       push;
   logic [ITEM_W-1:0]          push_data;
   logic                       q_pop;
   logic                       q_valid;
   logic [ITEM_W-1:0]          q_data;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [mslp_pkg::KEY_W-1:0] wr_data;
   logic [IDX_W-1:0]           rd_addr;
   logic [mslp_pkg::KEY_W-1:0] rd_data;
   mslp_pkg::rsp_type          rsp;

   mslp_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key       (req_key),
      .clearing      (clearing),
      .q_full        (q_full),
      .push          (push),
      .push_data     (push_data)
   );

   mslp_queue #(.WIDTH(ITEM_W), .DEPTH(mslp_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   mslp_ram #(.WIDTH(mslp_pkg::KEY_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mslp_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_ok        = rsp.ok;
   assign rsp_found_key = rsp.found_key;
   assign rsp_slot      = rsp.slot;

endmodule

[design/mslp_checker.sv]
// Port-level checker for the hash table unit, bound to the top level
`include "assert_macros.svh"

module mslp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_ok,
   input logic signed [mslp_pkg::KEY_W-1:0] rsp_found_key,
   input logic [mslp_pkg::SLOT_W-1:0]       rsp_slot
);

   logic [1+mslp_pkg::KEY_W+mslp_pkg::SLOT_W-1:0] rsp_beat;

   assign rsp_beat = {rsp_ok, rsp_found_key, rsp_slot};

   // store sweep holds off requests and no response is pending after reset
   `MSLP_ASSERT_NEXT_RST(a_reset_clear, reset, req_stall && !rsp_valid)

   // a miss or a full table reports no slot and no key
   `MSLP_ASSERT_ALWAYS(a_miss_zero, !rsp_valid || rsp_ok || (rsp_slot == '0 && rsp_found_key == '0))

   // a returned key implies a hit
   `MSLP_ASSERT_ALWAYS(a_key_hit, !(rsp_valid && rsp_found_key != '0) || rsp_ok)

   // stalled response beat holds
   `MSLP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))

endmodule

bind mid_square_linear_probe_hash_table_unit mslp_checker u_mslp_checker (.*);

[test/tb_top.sv]
// Self-checking testbench for the mid-square linear probe hash table unit
`timescale 1ns / 1ps

module tb_top;

   localparam int TABLE_SIZE  = mslp_pkg::TABLE_SIZE_DEFAULT;
   localparam int IDX_BITS    = $clog2(TABLE_SIZE);
   localparam int IDX_SHIFT   = (32 - IDX_BITS) / 2;
   localparam int N_RANDOM    = 900;
   localparam int N_DIRECTED  = 19;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = TABLE_SIZE + 24;

   typedef struct packed {
      logic        op;
      logic [31:0] key;
      logic        pinned;
      logic        ok;
      logic [31:0] found_key;
      logic [3:0]  slot;
   } step_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_operation;
   logic signed [mslp_pkg::KEY_W-1:0] req_key;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic                              rsp_ok;
   logic signed [mslp_pkg::KEY_W-1:0] rsp_found_key;
   logic [mslp_pkg::SLOT_W-1:0]       rsp_slot;

   logic [31:0]       table_mirror [TABLE_SIZE];
   mslp_pkg::rsp_type awaited_replies [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                stall_left = 0;

   // pinned rows carry the answer that is plain from an empty table or a dead key
   step_row_type directed_rows [N_DIRECTED] = '{
      '{mslp_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'h0000_0002, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'h0000_FFFF, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_INSERT, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0, 4'h0},
      '{mslp_pkg::OP_SEARCH, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0, 4'h0}
   };

   mid_square_linear_probe_hash_table_unit #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ok        (rsp_ok),
      .rsp_found_key (rsp_found_key),
      .rsp_slot      (rsp_slot)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int home_bucket_of(logic [31:0] k);
      logic [31:0] sq;
      logic [31:0] field;
      sq    = k * k;
      field = (sq >> IDX_SHIFT) & (32'hFFFF_FFFF >> (32 - IDX_BITS));
      return int'(field % TABLE_SIZE);
   endfunction

   // probe the mirror the way the block probes its store
   function automatic mslp_pkg::rsp_type probe_table(logic op, logic [31:0] k);
      mslp_pkg::rsp_type r;
      int                b;
      r = '0;
      b = home_bucket_of(k);
      for (int n = 0; n < TABLE_SIZE; n++) begin
         if (op == mslp_pkg::OP_INSERT) begin
            if (table_mirror[b] == 32'h0) begin
               table_mirror[b] = k;
               r.ok   = 1'b1;
               r.slot = b[mslp_pkg::SLOT_W-1:0];
               break;
            end
         end else begin
            if (table_mirror[b] == 32'h0)
               break;
            if (table_mirror[b] == k) begin
               r.ok        = 1'b1;
               r.found_key = k;
               r.slot      = b[mslp_pkg::SLOT_W-1:0];
               break;
            end
         end
         b = (b + 1) % TABLE_SIZE;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic int pick_gap(int idx);
      int r;
      if ((idx / 100) % 3 == 0)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_beat(input logic op, input logic [31:0] k, input logic pinned,
                            input mslp_pkg::rsp_type pinned_rsp, input int gap);
      mslp_pkg::rsp_type predicted;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= k;
      do @(posedge clock); while (req_stall);
      predicted = probe_table(op, k);
      awaited_replies.push_back(pinned ? pinned_rsp : predicted);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_insert_key();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 32'h0;
      if (r == 1) return table_mirror[$urandom_range(0, TABLE_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [31:0] random_search_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return table_mirror[$urandom_range(0, TABLE_SIZE - 1)];
      if (r < 55) return 32'h0;
      if (r < 65) return table_mirror[$urandom_range(0, TABLE_SIZE - 1)]
                         ^ (32'h1 << $urandom_range(0, 31));
      return $urandom;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // receiver stall pattern, rotating among no stalls, scattered stalls and long bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         case ((cycle_count / 256) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: begin
               if ($urandom_range(0, 19) == 0) begin
                  rsp_stall  <= 1'b1;
                  stall_left <= $urandom_range(10, 40);
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin : rsp_check
      mslp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("response beat with none pending");
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_ok !== want.ok)
               report_mismatch($sformatf("ok %b, want %b", rsp_ok, want.ok));
            if (rsp_found_key !== want.found_key)
               report_mismatch($sformatf("found_key %h, want %h", rsp_found_key,
                                         want.found_key));
            if (rsp_slot !== want.slot)
               report_mismatch($sformatf("slot %0d, want %0d", rsp_slot, want.slot));
         end
      end
   end

   initial begin : stimulus
      mslp_pkg::rsp_type pinned_rsp;
      logic              op;
      logic [31:0]       k;
      int                insert_pct;
      int                drain;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= mslp_pkg::OP_INSERT;
      req_key       <= '0;
      for (int i = 0; i < TABLE_SIZE; i++)
         table_mirror[i] = 32'h0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         pinned_rsp.ok        = directed_rows[i].ok;
         pinned_rsp.found_key = directed_rows[i].found_key;
         pinned_rsp.slot      = directed_rows[i].slot;
         send_beat(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pinned,
                   pinned_rsp, pick_gap(i + 100));
      end

      // table fills slowly at first so empty-slot stops stay reachable, then runs full
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            while (awaited_replies.size() != 0) @(posedge clock);
         end
         insert_pct = (i < 600) ? 3 : 25;
         op = ($urandom_range(0, 99) < insert_pct) ? mslp_pkg::OP_INSERT
                                                   : mslp_pkg::OP_SEARCH;
         k  = (op == mslp_pkg::OP_INSERT) ? random_insert_key() : random_search_key();
         send_beat(op, k, 1'b0, '0, pick_gap(i));
      end
      req_valid <= 1'b0;

      while (awaited_replies.size() != 0) @(posedge clock);
      for (drain = 0; drain < DRAIN_WAIT; drain++) @(posedge clock);
      if (mismatch_count == 0 && awaited_replies.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/mslp_pkg.sv
design/mslp_ram.sv
design/mslp_front.sv
design/mslp_queue.sv
design/mslp_back.sv
design/mid_square_linear_probe_hash_table_unit.sv
design/mslp_checker.sv
test/tb_top.sv
